// ===== rtl/iirdf1_pkg.sv =====
// Shared constants, codes and types of the direct form I IIR filter.
package iirdf1_pkg;

	// Default filter order; the tap count is one more.
	localparam int ORDER_DEF = 32;

	localparam int CMD_W    = 2;
	localparam int SAMPLE_W = 16;
	localparam int IDX_IN_W = 6;
	localparam int COEF_W   = 32;
	localparam int HIST_W   = 32;
	localparam int PROD_W   = COEF_W + HIST_W;
	// 64 taps of both products stay well below 2^54, so 56 bits never overflow.
	localparam int ACC_W    = 56;

	// Fraction bits dropped: feedback product to Q.28, history to Q.16, output to integer.
	localparam int FB_SHIFT   = 16;
	localparam int HIST_SHIFT = 12;
	localparam int OUT_SHIFT  = 28;

	localparam logic [CMD_W-1:0] CMD_FILTER  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_FF = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_FB = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [HIST_W-1:0]   y;
	} hist_entry_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} coef_pair_t;

	typedef struct packed {
		logic vld;
		logic fb;
		logic first;
		logic last;
	} mac_ctrl_t;

endpackage

// ===== rtl/iirdf1_coef_mem.sv =====
// Coefficient memory: feedforward and feedback taps, one registered read port.
module iirdf1_coef_mem import iirdf1_pkg::*; #(
	parameter int ORDER = ORDER_DEF,
	localparam int TAPS = ORDER + 1,
	localparam int IDX_W = $clog2(TAPS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic                     we_fb,
	input  logic [IDX_W-1:0]         waddr,
	input  logic signed [COEF_W-1:0] wdata,
	input  logic                     re,
	input  logic [IDX_W-1:0]         raddr,
	output coef_pair_t               rdata
);

	coef_pair_t       coef_mem_q [TAPS];
	coef_pair_t       rd_q;
	logic [TAPS-1:0]  b_vld_q;
	logic [TAPS-1:0]  a_vld_q;
	logic             rd_b_vld_q;
	logic             rd_a_vld_q;

	always_ff @(posedge clk) begin
		if (we && !we_fb) begin
			coef_mem_q[waddr].b <= wdata;
		end
		if (we && we_fb) begin
			coef_mem_q[waddr].a <= wdata;
		end
		if (re) begin
			rd_q <= coef_mem_q[raddr];
		end
	end

	// An entry never loaded since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_vld_q    <= '0;
			a_vld_q    <= '0;
			rd_b_vld_q <= 1'b0;
			rd_a_vld_q <= 1'b0;
		end else begin
			if (we && !we_fb) begin
				b_vld_q[waddr] <= 1'b1;
			end
			if (we && we_fb) begin
				a_vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_b_vld_q <= b_vld_q[raddr];
				rd_a_vld_q <= a_vld_q[raddr];
			end
		end
	end

	assign rdata.b = rd_b_vld_q ? rd_q.b : '0;
	assign rdata.a = rd_a_vld_q ? rd_q.a : '0;

endmodule

// ===== rtl/iirdf1_hist_mem.sv =====
// History memory: past input samples and past outputs, one registered read port.
module iirdf1_hist_mem import iirdf1_pkg::*; #(
	parameter int ORDER = ORDER_DEF,
	localparam int TAPS = ORDER + 1,
	localparam int IDX_W = $clog2(TAPS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  hist_entry_t      wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output hist_entry_t      rdata
);

	hist_entry_t      hist_mem_q [TAPS];
	hist_entry_t      rd_q;
	logic [TAPS-1:0]  vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			hist_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= hist_mem_q[raddr];
		end
	end

	// Entries not yet written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/iirdf1_mac.sv =====
// Shared multiply-accumulate unit with the final rounding and saturation.
module iirdf1_mac import iirdf1_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  mac_ctrl_t                  issue,
	input  coef_pair_t                 coef,
	input  hist_entry_t                hist,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       acc_done,
	output logic signed [HIST_W-1:0]   hist_y,
	output logic signed [SAMPLE_W-1:0] result,
	output logic                       sat
);

	localparam logic signed [ACC_W-1:0] HIST_RND = ACC_W'((1 << HIST_SHIFT) - 1);
	localparam logic signed [ACC_W-1:0] OUT_RND  = ACC_W'((1 << OUT_SHIFT) - 1);

	mac_ctrl_t                  ctrl_s1;
	mac_ctrl_t                  ctrl_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	logic signed [SAMPLE_W-1:0] x_sel;
	logic signed [COEF_W-1:0]   op_a;
	logic signed [HIST_W-1:0]   op_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_sh;
	logic signed [PROD_W-1:0]   term;
	logic signed [ACC_W-1:0]    hist_sum;
	logic signed [ACC_W-1:0]    hist_sh;
	logic signed [ACC_W-1:0]    out_sum;
	logic signed [ACC_W-1:0]    out_sh;
	logic                       hist_pos_ovf;
	logic                       hist_neg_ovf;
	logic                       out_pos_ovf;
	logic                       out_neg_ovf;

	// Stage 1: the memories' read data is present; choose operands and multiply.
	// Tap 0 takes the new sample in place of the stored one and has no feedback term.
	always_comb begin
		x_sel = ctrl_s1.first ? sample : hist.x;
		op_a  = ctrl_s1.fb ? coef.a : coef.b;
		if (ctrl_s1.fb) begin
			op_b = ctrl_s1.first ? '0 : hist.y;
		end else begin
			op_b = {{(HIST_W - SAMPLE_W){x_sel[SAMPLE_W-1]}}, x_sel};
		end
		prod = op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= issue;
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.vld) begin
			prod_s2 <= prod;
		end
	end

	// Stage 2: the feedback product is floored to 28 fraction bits and subtracted.
	always_comb begin
		prod_sh = prod_s2 >>> FB_SHIFT;
		term    = ctrl_s2.fb ? -prod_sh : prod_s2;
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q <= '0;
		end else if (ctrl_s2.vld) begin
			acc_q <= acc_q + term[ACC_W-1:0];
		end
	end

	assign acc_done = ctrl_s2.vld && ctrl_s2.last;

	// Truncation toward zero: negative values are biased before the arithmetic shift.
	always_comb begin
		hist_sum = acc_q + (acc_q[ACC_W-1] ? HIST_RND : '0);
		hist_sh  = hist_sum >>> HIST_SHIFT;
		out_sum  = acc_q + (acc_q[ACC_W-1] ? OUT_RND : '0);
		out_sh   = out_sum >>> OUT_SHIFT;

		hist_pos_ovf = !hist_sh[ACC_W-1] && (|hist_sh[ACC_W-2:HIST_W-1]);
		hist_neg_ovf = hist_sh[ACC_W-1] && !(&hist_sh[ACC_W-2:HIST_W-1]);
		out_pos_ovf  = !out_sh[ACC_W-1] && (|out_sh[ACC_W-2:SAMPLE_W-1]);
		out_neg_ovf  = out_sh[ACC_W-1] && !(&out_sh[ACC_W-2:SAMPLE_W-1]);

		if (hist_pos_ovf) begin
			hist_y = {1'b0, {(HIST_W - 1){1'b1}}};
		end else if (hist_neg_ovf) begin
			hist_y = {1'b1, {(HIST_W - 1){1'b0}}};
		end else begin
			hist_y = hist_sh[HIST_W-1:0];
		end

		if (out_pos_ovf) begin
			result = {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end else if (out_neg_ovf) begin
			result = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			result = out_sh[SAMPLE_W-1:0];
		end
		sat = out_pos_ovf || out_neg_ovf;
	end

endmodule

// ===== rtl/iir_direct_form_one_filter.sv =====
// Direct form I IIR filter: top level with the tap sequencer and the output register.
//
// Usage. Items arrive on the input channel (in_valid, in_ready) with the fields cmd,
// sample_in, coeff_index and coeff_value. A load command writes one feedforward or
// feedback coefficient in the cycle of its transfer and gives no result; a tap index
// above ORDER and the unused command code are taken and dropped. A filter command
// gives one result on the output channel (out_valid, out_ready): filtered_sample and
// saturated, the latter high when the output was clipped to the 16-bit range.
// Sequencing. A sample holds the filter from its transfer until the sequencer is back in idle:
// the single multiplier forms one product per cycle, a feedforward and a feedback product for
// each of the ORDER+1 taps, followed by the multiply and accumulate stages, the write-back and
// the return to idle. The result is presented in the cycle after the write-back.
// Load commands do not leave the idle state.
// Stalls. The result sits in an output register, so a new item is taken while an
// earlier result still waits. Should a second result be ready before the first has
// been taken, the filter holds in its final state and accepts nothing until then.
// Reset. The asynchronous reset clears all coefficients and histories to zero through
// per-entry valid bits, so the filter is ready to take items as soon as reset is released.
module iir_direct_form_one_filter import iirdf1_pkg::*; #(
	parameter int ORDER = ORDER_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [CMD_W-1:0]           cmd,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [IDX_IN_W-1:0]        coeff_index,
	input  logic signed [COEF_W-1:0]   coeff_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] filtered_sample,
	output logic                       saturated
);

	localparam int TAPS   = ORDER + 1;
	localparam int IDX_W  = $clog2(TAPS);
	localparam int STEP_W = $clog2(2 * TAPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * TAPS - 1);

	seq_state_t                 state_q;
	seq_state_t                 state_d;
	logic [STEP_W-1:0]          step_q;
	logic [IDX_W-1:0]           pos_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic                       sat_q;

	logic [IDX_W-1:0]           tap;
	logic [IDX_W:0]             pos_ext;
	logic [IDX_W:0]             tap_ext;
	logic [IDX_W:0]             back_ext;
	logic [IDX_W-1:0]           hist_raddr;
	logic                       in_range;
	logic                       start;
	logic                       coef_we;
	logic                       rd_en;
	logic                       commit;
	logic                       out_free;
	mac_ctrl_t                  issue;
	coef_pair_t                 coef_rd;
	hist_entry_t                hist_rd;
	hist_entry_t                hist_wr;
	logic                       acc_done;
	logic signed [HIST_W-1:0]   hist_y;
	logic signed [SAMPLE_W-1:0] mac_result;
	logic                       mac_sat;

	// Each tap occupies two steps: the even step reads both memories, the feedforward
	// product follows, and the feedback product uses the same read data in the cycle after it.
	assign tap     = step_q[STEP_W-1:1];
	assign pos_ext = {1'b0, pos_q};
	assign tap_ext = {1'b0, tap};

	// The history is circular: tap i sits i entries behind the write position.
	always_comb begin
		if (pos_q >= tap) begin
			back_ext = pos_ext - tap_ext;
		end else begin
			back_ext = pos_ext + (IDX_W + 1)'(TAPS) - tap_ext;
		end
		hist_raddr = back_ext[IDX_W-1:0];
	end

	assign in_range = ({1'b0, coeff_index} <= (IDX_IN_W + 1)'(ORDER));
	assign out_free = !out_valid_q || out_ready;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && cmd == CMD_FILTER) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (acc_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. Histories are written only in the final state and read only
	// while running, so the read-modify-write of one sample never overlaps another.
	always_comb begin
		in_ready    = 1'b0;
		rd_en       = 1'b0;
		commit      = 1'b0;
		issue       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_RUN: begin
				rd_en       = !step_q[0];
				issue.vld   = 1'b1;
				issue.fb    = step_q[0];
				issue.first = (tap == '0);
				issue.last  = (step_q == LAST_STEP);
			end
			ST_DRAIN: begin
				in_ready = 1'b0;
			end
			ST_DONE: begin
				commit = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign start   = in_ready && in_valid && (cmd == CMD_FILTER);
	assign coef_we = in_ready && in_valid && in_range
		&& ((cmd == CMD_LOAD_FF) || (cmd == CMD_LOAD_FB));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				step_q <= '0;
			end else if (state_q == ST_RUN) begin
				step_q <= step_q + 1'b1;
			end
			if (commit) begin
				pos_q <= (pos_q == IDX_W'(ORDER)) ? '0 : pos_q + 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sample_q <= sample_in;
		end
		if (commit) begin
			filtered_q <= mac_result;
			sat_q      <= mac_sat;
		end
	end

	assign hist_wr.x = sample_q;
	assign hist_wr.y = hist_y;

	iirdf1_coef_mem #(
		.ORDER (ORDER)
	) u_coef_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (coef_we),
		.we_fb  (cmd == CMD_LOAD_FB),
		.waddr  (coeff_index[IDX_W-1:0]),
		.wdata  (coeff_value),
		.re     (rd_en),
		.raddr  (tap),
		.rdata  (coef_rd)
	);

	iirdf1_hist_mem #(
		.ORDER (ORDER)
	) u_hist_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (commit),
		.waddr  (pos_q),
		.wdata  (hist_wr),
		.re     (rd_en),
		.raddr  (hist_raddr),
		.rdata  (hist_rd)
	);

	iirdf1_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (start),
		.issue    (issue),
		.coef     (coef_rd),
		.hist     (hist_rd),
		.sample   (sample_q),
		.acc_done (acc_done),
		.hist_y   (hist_y),
		.result   (mac_result),
		.sat      (mac_sat)
	);

	assign out_valid       = out_valid_q;
	assign filtered_sample = filtered_q;
	assign saturated       = sat_q;

	// The last product reaches the accumulator only once the sequencer has stopped.
	assert property (@(posedge clk) disable iff (!arst_n)
		acc_done |-> (state_q == ST_DRAIN))
		else $error("accumulation finished outside the drain state");

	// A past tap never reads the entry that the current sample will overwrite.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && tap != '0) |-> (hist_raddr != pos_q))
		else $error("history read hit the write position");

	// The write position stays inside the circular history.
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= IDX_W'(ORDER))
		else $error("write position out of range");

	// A write-back always leaves a result waiting and the sequencer idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (out_valid_q && state_q == ST_IDLE))
		else $error("write-back did not present a result");

endmodule
